[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication or property on every clock, outside reset.
`define TCON_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds, outside reset.
`define TCON_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCON_ASSERT(label, prop, msg)
`define TCON_NEVER(label, cond, msg)
`endif
`endif

[rtl/tcon_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcon_pkg
// Types and constants of the text console.
// ----------------------------------------------------------------------------
package tcon_pkg;

    typedef enum logic [2:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_BLINK      = 3'd1,
        OP_SET_CURSOR = 3'd2,
        OP_MOVE       = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_PUT_AT     = 3'd5,
        OP_READ_CELL  = 3'd6,
        OP_LINE_START = 3'd7
    } op_t;

    localparam logic [1:0] REG_TEXT_ATTR = 2'd0;
    localparam logic [1:0] REG_BLINK_EN  = 2'd1;

    localparam int CELL_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int POS_OUT_W = 11;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  BLANK_CODE   = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0F20;
    localparam logic [7:0]  RESET_ATTR   = 8'h0F;

    typedef logic [CELL_W-1:0] cell_t;

endpackage

[rtl/tcon_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcon_req_if
// Request channel: one console operation per request.
// ----------------------------------------------------------------------------
interface tcon_req_if;
    logic                valid;
    logic                ready;
    tcon_pkg::op_t       op;
    logic [7:0]          char_code;
    logic [4:0]          target_row;
    logic [6:0]          target_column;
    logic signed [7:0]   row_delta;
    logic signed [7:0]   column_delta;

    modport source (output valid, op, char_code, target_row, target_column,
                    row_delta, column_delta, input ready);
    modport sink   (input valid, op, char_code, target_row, target_column,
                    row_delta, column_delta, output ready);
endinterface

[rtl/tcon_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcon_rsp_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface tcon_rsp_if;
    logic         valid;
    logic         ready;
    logic [15:0]  cell_value;
    logic [4:0]   cursor_row_out;
    logic [6:0]   cursor_column_out;
    logic [10:0]  hw_cursor_position;
    logic         hw_cursor_enabled;

    modport source (output valid, cell_value, cursor_row_out, cursor_column_out,
                    hw_cursor_position, hw_cursor_enabled, input ready);
    modport sink   (input valid, cell_value, cursor_row_out, cursor_column_out,
                    hw_cursor_position, hw_cursor_enabled, output ready);
endinterface

[rtl/tcon_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcon_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcon_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [7:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tcon_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcon_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/text_console_with_blink_cursor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_with_blink_cursor
// Character-cell screen engine with a blinking cursor mark.
// ----------------------------------------------------------------------------
// The screen lives in one RAM of ROWS*COLUMNS cells with a registered read,
// driven by a sequencer that does one access per cycle, so requests are
// handled one at a time. After reset a clearing pass writes every cell blank
// before the first request is taken; configuration writes are taken at any
// time. A blink tick does nothing when blinking is disabled, hides the mark
// when it is shown and shows it when it is hidden. A scroll (put char past
// the last row) copies every line one line up and blanks the last row, and
// clear writes every cell blank.
// A new request is taken while the previous result still waits at the output.
module text_console_with_blink_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic   clk,
    input  logic   rst_n,
    tcon_req_if.sink   req,
    tcon_rsp_if.source rsp,
    tcon_cfg_if.sink   cfg
);
    import tcon_pkg::*;
    `include "assert_macros.svh"

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int COPY_LAST = CELLS - COLUMNS - 1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HIDE, S_PUT, S_SCR_RD, S_SCR_WR, S_BLANK, S_FILL,
        S_SHOW_RD, S_SHOW_WR, S_PUT_AT, S_READ_RD, S_READ_WAIT, S_MOVE, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [7:0]      ch_reg, ch_next;
    logic [RW-1:0]   tr_reg, tr_next;
    logic [CW-1:0]   tc_reg, tc_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic            mark_on_reg, mark_on_next;
    logic            mark_vis_reg, mark_vis_next;
    logic [RW-1:0]   mark_row_reg, mark_row_next;
    logic [CW-1:0]   mark_col_reg, mark_col_next;
    cell_t           saved_reg, saved_next;
    logic [10:0]     hw_pos_reg, hw_pos_next;
    logic            hw_en_reg, hw_en_next;
    logic [7:0]      attr_reg, attr_next;
    logic            blink_en_reg, blink_en_next;
    logic [AW-1:0]   idx_reg, idx_next;
    cell_t           rd_cell_reg, rd_cell_next;
    logic            out_valid_reg, out_valid_next;
    cell_t           out_cell_reg, out_cell_next;
    logic [4:0]      out_row_reg, out_row_next;
    logic [6:0]      out_col_reg, out_col_next;
    logic [10:0]     out_pos_reg, out_pos_next;
    logic            out_en_reg, out_en_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    cell_t           ram_wdata, ram_rdata;

    logic [RW-1:0]   tr_clamp, mv_row;
    logic [CW-1:0]   tc_clamp, mv_col;
    logic signed [9:0] row_sum, col_sum;

    function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
        return AW'(int'(r) * COLUMNS + int'(c));
    endfunction

    tcon_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // target clamp and relative move
    always_comb
    begin
        tr_clamp = (int'(req.target_row) >= ROWS) ? RW'(ROWS - 1) : RW'(req.target_row);
        tc_clamp = (int'(req.target_column) >= COLUMNS) ? CW'(COLUMNS - 1)
                                                        : CW'(req.target_column);
        row_sum = $signed(10'(row_reg)) + 10'(req.row_delta);
        col_sum = $signed(10'(col_reg)) + 10'(req.column_delta);
        if (row_sum < 0)
            mv_row = '0;
        else if (row_sum >= $signed(10'(ROWS)))
            mv_row = RW'(ROWS - 1);
        else
            mv_row = RW'(row_sum);
        if (col_sum < 0)
            mv_col = '0;
        else if (col_sum >= $signed(10'(COLUMNS)))
            mv_col = CW'(COLUMNS - 1);
        else
            mv_col = CW'(col_sum);
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        tr_next        = tr_reg;
        tc_next        = tc_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        mark_on_next   = mark_on_reg;
        mark_vis_next  = mark_vis_reg;
        mark_row_next  = mark_row_reg;
        mark_col_next  = mark_col_reg;
        saved_next     = saved_reg;
        hw_pos_next    = hw_pos_reg;
        hw_en_next     = hw_en_reg;
        attr_next      = attr_reg;
        blink_en_next  = blink_en_reg;
        idx_next       = idx_reg;
        rd_cell_next   = rd_cell_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_cell_next  = out_cell_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_pos_next   = out_pos_reg;
        out_en_next    = out_en_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // configuration writes
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TEXT_ATTR: attr_next = cfg.data;
                REG_BLINK_EN:  blink_en_next = cfg.data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = RESET_CELL;
                if (idx_reg == AW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.op;
                    ch_next = req.char_code;
                    tr_next = tr_clamp;
                    tc_next = tc_clamp;
                    unique case (req.op) inside
                        OP_PUT_CHAR, OP_SET_CURSOR: state_next = S_HIDE;
                        OP_BLINK:
                        begin
                            if (!blink_en_reg)
                                state_next = S_DONE;
                            else if (mark_vis_reg)
                                state_next = S_HIDE;
                            else
                                state_next = S_SHOW_RD;
                        end
                        OP_MOVE:
                        begin
                            row_next   = mv_row;
                            col_next   = mv_col;
                            state_next = S_MOVE;
                        end
                        OP_CLEAR:
                        begin
                            // drop the mark; the fill overwrites its cell
                            hw_en_next    = 1'b0;
                            mark_on_next  = 1'b0;
                            mark_vis_next = 1'b0;
                            idx_next      = '0;
                            state_next    = S_FILL;
                        end
                        OP_PUT_AT:    state_next = S_PUT_AT;
                        OP_READ_CELL: state_next = S_READ_RD;
                        default:
                        begin
                            col_next   = '0;
                            state_next = S_HIDE;
                        end
                    endcase
                end
            end
            S_HIDE:
            begin
                mark_vis_next = 1'b0;
                if (mark_on_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = cell_addr(mark_row_reg, mark_col_reg);
                    ram_wdata    = saved_reg;
                    mark_on_next = 1'b0;
                end
                case (op_reg)
                    OP_PUT_CHAR: state_next = S_PUT;
                    OP_BLINK:    state_next = S_DONE;
                    OP_SET_CURSOR:
                    begin
                        row_next   = tr_reg;
                        col_next   = tc_reg;
                        state_next = S_SHOW_RD;
                    end
                    default:     state_next = S_SHOW_RD;
                endcase
            end
            S_PUT:
            begin
                state_next = S_SHOW_RD;
                if (ch_reg != NEWLINE_CODE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(row_reg, col_reg);
                    ram_wdata = {attr_reg, ch_reg};
                end
                if (ch_reg == NEWLINE_CODE || col_reg == CW'(COLUMNS - 1))
                begin
                    col_next = '0;
                    if (row_reg == RW'(ROWS - 1))
                    begin
                        idx_next   = '0;
                        state_next = S_SCR_RD;
                    end
                    else
                        row_next = row_reg + 1'b1;
                end
                else
                    col_next = col_reg + 1'b1;
            end
            // scroll: copy each cell one line up
            S_SCR_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg + AW'(COLUMNS);
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + 1'b1;
                state_next = (idx_reg == AW'(COPY_LAST)) ? S_BLANK : S_SCR_RD;
            end
            S_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {attr_reg, BLANK_CODE};
                if (idx_reg == AW'(CELLS - 1))
                begin
                    row_next   = RW'(ROWS - 1);
                    state_next = S_SHOW_RD;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {attr_reg, BLANK_CODE};
                if (idx_reg == AW'(CELLS - 1))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_SHOW_RD;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            // show mark unless it is already on: latch position and fetch the cell
            S_SHOW_RD:
            begin
                if (mark_on_reg)
                    state_next = S_DONE;
                else
                begin
                    mark_row_next = row_reg;
                    mark_col_next = col_reg;
                    ram_re        = 1'b1;
                    ram_raddr     = cell_addr(row_reg, col_reg);
                    state_next    = S_SHOW_WR;
                end
            end
            S_SHOW_WR:
            begin
                saved_next    = ram_rdata;
                ram_we        = 1'b1;
                ram_waddr     = cell_addr(mark_row_reg, mark_col_reg);
                ram_wdata     = {ram_rdata[11:8], ram_rdata[15:12], ram_rdata[7:0]};
                mark_on_next  = 1'b1;
                mark_vis_next = 1'b1;
                state_next    = S_DONE;
            end
            S_PUT_AT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cell_addr(tr_reg, tc_reg);
                ram_wdata  = {attr_reg, ch_reg};
                state_next = S_DONE;
            end
            S_READ_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cell_addr(tr_reg, tc_reg);
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                rd_cell_next = ram_rdata;
                state_next   = S_DONE;
            end
            S_MOVE:
            begin
                hw_pos_next = 11'(int'(row_reg) * COLUMNS + int'(col_reg));
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = (op_reg == OP_READ_CELL) ? rd_cell_reg : '0;
                    out_row_next   = ROW_OUT_W'(row_reg);
                    out_col_next   = COL_OUT_W'(col_reg);
                    out_pos_next   = hw_pos_reg;
                    out_en_next    = hw_en_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            mark_on_reg   <= 1'b0;
            mark_vis_reg  <= 1'b0;
            mark_row_reg  <= '0;
            mark_col_reg  <= '0;
            saved_reg     <= '0;
            hw_pos_reg    <= '0;
            hw_en_reg     <= 1'b1;
            attr_reg      <= RESET_ATTR;
            blink_en_reg  <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            mark_on_reg   <= mark_on_next;
            mark_vis_reg  <= mark_vis_next;
            mark_row_reg  <= mark_row_next;
            mark_col_reg  <= mark_col_next;
            saved_reg     <= saved_next;
            hw_pos_reg    <= hw_pos_next;
            hw_en_reg     <= hw_en_next;
            attr_reg      <= attr_next;
            blink_en_reg  <= blink_en_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload and result data
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        tr_reg       <= tr_next;
        tc_reg       <= tc_next;
        rd_cell_reg  <= rd_cell_next;
        out_cell_reg <= out_cell_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_pos_reg  <= out_pos_next;
        out_en_reg   <= out_en_next;
    end

    assign req.ready             = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign rsp.valid             = out_valid_reg;
    assign rsp.cell_value        = out_cell_reg;
    assign rsp.cursor_row_out    = out_row_reg;
    assign rsp.cursor_column_out = out_col_reg;
    assign rsp.hw_cursor_position = out_pos_reg;
    assign rsp.hw_cursor_enabled = out_en_reg;

    // checks
    `TCON_ASSERT(a_one_request, (req.valid && req.ready) |=> !req.ready, "request overlap")
    `TCON_ASSERT(a_mark_pair, mark_on_reg == mark_vis_reg, "mark flags disagree")
    `TCON_ASSERT(a_cursor_range, (int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS), "bad cursor")
    `TCON_NEVER(a_waddr_range, ram_we && (int'(ram_waddr) >= CELLS), "write beyond screen")
endmodule
